// ----- src/cafu_pkg.sv -----
package cafu_pkg;

    typedef enum logic [4:0] {
        OP_ADD     = 5'd0,
        OP_ADC     = 5'd1,
        OP_SUB     = 5'd2,
        OP_SBC     = 5'd3,
        OP_CP      = 5'd4,
        OP_AND     = 5'd5,
        OP_XOR     = 5'd6,
        OP_OR      = 5'd7,
        OP_INC     = 5'd8,
        OP_DEC     = 5'd9,
        OP_RLC     = 5'd10,
        OP_RRC     = 5'd11,
        OP_RL      = 5'd12,
        OP_RR      = 5'd13,
        OP_SLA     = 5'd14,
        OP_SLL     = 5'd15,
        OP_SRA     = 5'd16,
        OP_SRL     = 5'd17,
        OP_BIT     = 5'd18,
        OP_SET     = 5'd19,
        OP_RES     = 5'd20,
        OP_ADD16   = 5'd21,
        OP_ADC16   = 5'd22,
        OP_SBC16   = 5'd23,
        OP_RRD     = 5'd24,
        OP_RLD     = 5'd25,
        OP_INFLAGS = 5'd26
    } t_op;

    // Decoded item: adder operands already prepared (subtrahend inverted)
    typedef struct packed {
        t_op         op;
        logic [7:0]  a8;
        logic [7:0]  b8;
        logic [15:0] x;
        logic [15:0] y;
        logic        cin;
        logic        sub;
        logic [2:0]  bit_idx;
        logic [7:0]  fi;
    } t_dec;

    // Executed item: result bytes plus raw condition bits for the flag stage
    typedef struct packed {
        t_op         op;
        logic [15:0] res;
        logic [7:0]  res2;
        logic [7:0]  fi;
        logic        sub;
        logic        c8;
        logic        c16;
        logic        hc4;
        logic        hc12;
        logic        v8;
        logic        v16;
        logic        s8;
        logic        s16;
        logic        z8;
        logic        z16;
        logic        sc;
        logic        tb;
        logic        bi7;
    } t_ex;

endpackage

// ----- src/cpu_alu_with_flags_unit.sv -----
// Channel   Handshake            Payload
// in        i_valid / o_ready    i_op, i_operand_a, i_operand_b, i_bit_index, i_flags_in
// out       o_valid / i_ready    o_result, o_second_result, o_flags_out
//
// One item per cycle sustained while i_ready stays high; a taken input beat passes through
// the decode, execute and flag registers in turn before o_valid rises.
// Stages: decode and operand prep, 17-bit adder with logic and shifts, flag build.
// Each stage holds its own valid bit and loads whenever it is empty or its successor
// moves, so a stall fills the bubbles first and then holds o_ready low.
// i_rst_n is synchronous and clears the valid bits only.
module cpu_alu_with_flags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [4:0]  i_op,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [2:0]  i_bit_index,
    input  logic [7:0]  i_flags_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_result,
    output logic [7:0]  o_second_result,
    output logic [7:0]  o_flags_out
);

    cafu_pkg::t_dec w_dec;
    cafu_pkg::t_ex  w_ex;
    logic           w_dec_valid;
    logic           w_ex_valid;
    logic           w_ex_ready;
    logic           w_flag_ready;

    cafu_dec u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .i_bit_index (i_bit_index),
        .i_flags_in  (i_flags_in),
        .o_valid     (w_dec_valid),
        .i_ready     (w_ex_ready),
        .o_dec       (w_dec)
    );

    cafu_exec u_exec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .o_ready (w_ex_ready),
        .i_dec   (w_dec),
        .o_valid (w_ex_valid),
        .i_ready (w_flag_ready),
        .o_ex    (w_ex)
    );

    cafu_flag u_flag (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_ex_valid),
        .o_ready         (w_flag_ready),
        .i_ex            (w_ex),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_result        (o_result),
        .o_second_result (o_second_result),
        .o_flags_out     (o_flags_out)
    );

`ifndef SYNTH
    // backpressure reaches the input only when every stage is full
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == !(w_dec_valid && w_ex_valid && o_valid && !i_ready))
        else $error("o_ready does not match pipeline occupancy");

    // a beat in the execute stage lands in the output register when it can move
    a_ex_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ex_valid && (!o_valid || i_ready)) |=> o_valid)
        else $error("execute beat dropped");

    // a beat in decode reaches execute when execute can load
    a_dec_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dec_valid && w_ex_ready) |=> w_ex_valid)
        else $error("decode beat dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_valid && !w_ex_valid && !w_dec_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ----- src/cafu_dec.sv -----
module cafu_dec (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [4:0]      i_op,
    input  logic [15:0]     i_operand_a,
    input  logic [15:0]     i_operand_b,
    input  logic [2:0]      i_bit_index,
    input  logic [7:0]      i_flags_in,
    output logic            o_valid,
    input  logic            i_ready,
    output cafu_pkg::t_dec  o_dec
);

    logic           r_valid;
    cafu_pkg::t_dec r_dec;
    cafu_pkg::t_dec n_dec;
    logic           w_en;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    always_comb begin
        n_dec         = '0;
        n_dec.op      = cafu_pkg::t_op'(i_op);
        n_dec.a8      = i_operand_a[7:0];
        n_dec.b8      = i_operand_b[7:0];
        n_dec.bit_idx = i_bit_index;
        n_dec.fi      = i_flags_in;
        n_dec.x       = {8'h00, i_operand_a[7:0]};
        n_dec.y       = {8'h00, i_operand_b[7:0]};
        n_dec.cin     = 1'b0;
        n_dec.sub     = 1'b0;
        // subtract as a + ~b + !borrow_in
        case (cafu_pkg::t_op'(i_op))
            cafu_pkg::OP_ADC: begin
                n_dec.cin = i_flags_in[0];
            end
            cafu_pkg::OP_SUB, cafu_pkg::OP_CP: begin
                n_dec.y   = {8'h00, ~i_operand_b[7:0]};
                n_dec.cin = 1'b1;
                n_dec.sub = 1'b1;
            end
            cafu_pkg::OP_SBC: begin
                n_dec.y   = {8'h00, ~i_operand_b[7:0]};
                n_dec.cin = ~i_flags_in[0];
                n_dec.sub = 1'b1;
            end
            cafu_pkg::OP_INC: begin
                n_dec.y = 16'h0001;
            end
            cafu_pkg::OP_DEC: begin
                n_dec.y   = 16'h00FE;
                n_dec.cin = 1'b1;
                n_dec.sub = 1'b1;
            end
            cafu_pkg::OP_ADD16: begin
                n_dec.x = i_operand_a;
                n_dec.y = i_operand_b;
            end
            cafu_pkg::OP_ADC16: begin
                n_dec.x   = i_operand_a;
                n_dec.y   = i_operand_b;
                n_dec.cin = i_flags_in[0];
            end
            cafu_pkg::OP_SBC16: begin
                n_dec.x   = i_operand_a;
                n_dec.y   = ~i_operand_b;
                n_dec.cin = ~i_flags_in[0];
                n_dec.sub = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_valid;
    assign o_dec   = r_dec;

endmodule

// ----- src/cafu_exec.sv -----
module cafu_exec (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cafu_pkg::t_dec  i_dec,
    output logic            o_valid,
    input  logic            i_ready,
    output cafu_pkg::t_ex   o_ex
);

    logic          r_valid;
    cafu_pkg::t_ex r_ex;
    cafu_pkg::t_ex n_ex;
    logic          w_en;
    logic [16:0]   w_sum;
    logic [15:0]   w_hx;
    logic [15:0]   w_ov;
    logic [7:0]    w_a;
    logic [7:0]    w_b;
    logic [7:0]    w_mask;
    logic          w_c;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    assign w_a    = i_dec.a8;
    assign w_b    = i_dec.b8;
    assign w_c    = i_dec.fi[0];
    assign w_mask = 8'h01 << i_dec.bit_idx;
    assign w_sum  = {1'b0, i_dec.x} + {1'b0, i_dec.y} + {16'h0000, i_dec.cin};
    // carries into each bit, and signed overflow taken on the prepared operand
    assign w_hx   = i_dec.x ^ i_dec.y ^ w_sum[15:0];
    assign w_ov   = ~(i_dec.x ^ i_dec.y) & (i_dec.x ^ w_sum[15:0]);

    always_comb begin
        n_ex      = '0;
        n_ex.op   = i_dec.op;
        n_ex.fi   = i_dec.fi;
        n_ex.sub  = i_dec.sub;
        n_ex.c8   = w_sum[8];
        n_ex.c16  = w_sum[16];
        n_ex.hc4  = w_hx[4];
        n_ex.hc12 = w_hx[12];
        n_ex.v8   = w_ov[7];
        n_ex.v16  = w_ov[15];
        n_ex.s8   = w_sum[7];
        n_ex.s16  = w_sum[15];
        n_ex.z8   = (w_sum[7:0] == 8'h00);
        n_ex.z16  = (w_sum[15:0] == 16'h0000);
        n_ex.tb   = w_a[i_dec.bit_idx];
        n_ex.bi7  = (i_dec.bit_idx == 3'd7);
        n_ex.sc   = 1'b0;
        case (i_dec.op)
            cafu_pkg::OP_ADD, cafu_pkg::OP_ADC, cafu_pkg::OP_SUB, cafu_pkg::OP_SBC,
            cafu_pkg::OP_INC, cafu_pkg::OP_DEC: begin
                n_ex.res = {8'h00, w_sum[7:0]};
            end
            cafu_pkg::OP_CP, cafu_pkg::OP_INFLAGS: n_ex.res = {8'h00, w_a};
            cafu_pkg::OP_AND: n_ex.res = {8'h00, w_a & w_b};
            cafu_pkg::OP_XOR: n_ex.res = {8'h00, w_a ^ w_b};
            cafu_pkg::OP_OR:  n_ex.res = {8'h00, w_a | w_b};
            cafu_pkg::OP_RLC: begin
                n_ex.res = {8'h00, w_a[6:0], w_a[7]};
                n_ex.sc  = w_a[7];
            end
            cafu_pkg::OP_RRC: begin
                n_ex.res = {8'h00, w_a[0], w_a[7:1]};
                n_ex.sc  = w_a[0];
            end
            cafu_pkg::OP_RL: begin
                n_ex.res = {8'h00, w_a[6:0], w_c};
                n_ex.sc  = w_a[7];
            end
            cafu_pkg::OP_RR: begin
                n_ex.res = {8'h00, w_c, w_a[7:1]};
                n_ex.sc  = w_a[0];
            end
            cafu_pkg::OP_SLA: begin
                n_ex.res = {8'h00, w_a[6:0], 1'b0};
                n_ex.sc  = w_a[7];
            end
            cafu_pkg::OP_SLL: begin
                n_ex.res = {8'h00, w_a[6:0], 1'b1};
                n_ex.sc  = w_a[7];
            end
            cafu_pkg::OP_SRA: begin
                n_ex.res = {8'h00, w_a[7], w_a[7:1]};
                n_ex.sc  = w_a[0];
            end
            cafu_pkg::OP_SRL: begin
                n_ex.res = {8'h00, 1'b0, w_a[7:1]};
                n_ex.sc  = w_a[0];
            end
            cafu_pkg::OP_SET: n_ex.res = {8'h00, w_a | w_mask};
            cafu_pkg::OP_RES: n_ex.res = {8'h00, w_a & ~w_mask};
            cafu_pkg::OP_ADD16, cafu_pkg::OP_ADC16, cafu_pkg::OP_SBC16: begin
                n_ex.res = w_sum[15:0];
            end
            cafu_pkg::OP_RRD: begin
                n_ex.res  = {8'h00, w_a[7:4], w_b[3:0]};
                n_ex.res2 = {w_a[3:0], w_b[7:4]};
            end
            cafu_pkg::OP_RLD: begin
                n_ex.res  = {8'h00, w_a[7:4], w_b[7:4]};
                n_ex.res2 = {w_b[3:0], w_a[3:0]};
            end
            default: n_ex.res = 16'h0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ex <= n_ex;
        end
    end

    assign o_valid = r_valid;
    assign o_ex    = r_ex;

endmodule

// ----- src/cafu_flag.sv -----
module cafu_flag (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cafu_pkg::t_ex   i_ex,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [15:0]     o_result,
    output logic [7:0]      o_second_result,
    output logic [7:0]      o_flags_out
);

    logic        r_valid;
    logic [15:0] r_result;
    logic [7:0]  r_second;
    logic [7:0]  r_flags;
    logic [7:0]  n_flags;
    logic        w_en;
    logic [7:0]  w_szp;
    logic        w_h8;
    logic        w_h16;
    logic        w_cy8;
    logic        w_cy16;

    assign w_en    = !r_valid || i_ready;
    assign o_ready = w_en;

    // S, Z and even parity of the result byte
    assign w_szp = {i_ex.res[7], (i_ex.res[7:0] == 8'h00), 3'b000, ~^i_ex.res[7:0], 2'b00};

    // flip carries back into borrows on subtract
    assign w_h8   = i_ex.hc4 ^ i_ex.sub;
    assign w_h16  = i_ex.hc12 ^ i_ex.sub;
    assign w_cy8  = i_ex.c8 ^ i_ex.sub;
    assign w_cy16 = i_ex.c16 ^ i_ex.sub;

    always_comb begin
        case (i_ex.op)
            cafu_pkg::OP_ADD, cafu_pkg::OP_ADC, cafu_pkg::OP_SUB, cafu_pkg::OP_SBC,
            cafu_pkg::OP_CP: begin
                n_flags = {i_ex.s8, i_ex.z8, 1'b0, w_h8, 1'b0, i_ex.v8, i_ex.sub, w_cy8};
            end
            cafu_pkg::OP_INC, cafu_pkg::OP_DEC: begin
                n_flags = {i_ex.s8, i_ex.z8, 1'b0, w_h8, 1'b0, i_ex.v8, i_ex.sub,
                           i_ex.fi[0]};
            end
            cafu_pkg::OP_AND: n_flags = w_szp | 8'h10;
            cafu_pkg::OP_XOR, cafu_pkg::OP_OR: n_flags = w_szp;
            cafu_pkg::OP_RLC, cafu_pkg::OP_RRC, cafu_pkg::OP_RL, cafu_pkg::OP_RR,
            cafu_pkg::OP_SLA, cafu_pkg::OP_SLL, cafu_pkg::OP_SRA, cafu_pkg::OP_SRL: begin
                n_flags = {w_szp[7:1], i_ex.sc};
            end
            cafu_pkg::OP_BIT: begin
                n_flags = {i_ex.bi7 & i_ex.tb, ~i_ex.tb, 1'b0, 1'b1, 1'b0, ~i_ex.tb, 1'b0,
                           i_ex.fi[0]};
            end
            cafu_pkg::OP_ADD16: begin
                n_flags = {i_ex.fi[7], i_ex.fi[6], 1'b0, i_ex.hc12, 1'b0, i_ex.fi[2], 1'b0,
                           i_ex.c16};
            end
            cafu_pkg::OP_ADC16, cafu_pkg::OP_SBC16: begin
                n_flags = {i_ex.s16, i_ex.z16, 1'b0, w_h16, 1'b0, i_ex.v16, i_ex.sub,
                           w_cy16};
            end
            cafu_pkg::OP_RRD, cafu_pkg::OP_RLD, cafu_pkg::OP_INFLAGS: begin
                n_flags = {w_szp[7:1], i_ex.fi[0]};
            end
            default: n_flags = i_ex.fi;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_result <= i_ex.res;
            r_second <= i_ex.res2;
            r_flags  <= n_flags;
        end
    end

    assign o_valid         = r_valid;
    assign o_result        = r_result;
    assign o_second_result = r_second;
    assign o_flags_out     = r_flags;

endmodule
